// ===== sv/dnsc_pkg.sv =====
`timescale 1ns / 1ps

package dnsc_pkg;

    localparam int TOTAL_W = 9;
    localparam int LABEL_W = 7;

    localparam logic [TOTAL_W-1:0] TOTAL_SAT = 9'd511;
    localparam logic [LABEL_W-1:0] LABEL_SAT = 7'd127;

    localparam logic [7:0] CH_END    = 8'h00;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_HYPHEN = 8'h2D;

    localparam logic [7:0] MAX_LENGTH_RST = 8'd253;
    localparam logic [5:0] MAX_LABEL_RST  = 6'd63;

    // Register indexes on the configuration port
    localparam logic REG_MAX_LENGTH = 1'b0;
    localparam logic REG_MAX_LABEL  = 1'b1;

    typedef struct packed {
        logic [TOTAL_W-1:0] total_count;
        logic [LABEL_W-1:0] label_count;
        logic               seen_dot;
        logic               prev_dot;
        logic               pending_hyphen;
        logic               failed;
    } scan_state_t;

    typedef struct packed {
        logic push;
        logic valid_res;
    } verdict_t;

    function automatic logic is_alnum(input logic [7:0] c);
        is_alnum = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h7A) ||
                   (c >= 8'h41 && c <= 8'h5A);
    endfunction

endpackage

// ===== sv/dnsc_rule.sv =====
`timescale 1ns / 1ps

module dnsc_rule (
    input  logic [7:0]                ch,
    input  dnsc_pkg::scan_state_t     cur,
    input  logic [7:0]                max_length,
    input  logic [5:0]                max_label,
    output dnsc_pkg::scan_state_t     nxt,
    output dnsc_pkg::verdict_t        verdict
);

    logic [dnsc_pkg::LABEL_W-1:0] label_grow;
    logic                         label_over;

    // Saturating label growth and its limit check
    assign label_grow = (cur.label_count == dnsc_pkg::LABEL_SAT) ? cur.label_count
                        : cur.label_count + 1'b1;
    assign label_over = label_grow > {1'b0, max_label};

    always_comb begin
        nxt               = cur;
        verdict.push      = 1'b0;
        verdict.valid_res = 1'b0;
        if (ch == dnsc_pkg::CH_END) begin
            verdict.push      = 1'b1;
            verdict.valid_res = !cur.failed && (cur.total_count != '0) &&
                                (cur.total_count <= {1'b0, max_length}) &&
                                cur.seen_dot && !cur.prev_dot && !cur.pending_hyphen;
            nxt = '0;
        end else begin
            if (cur.total_count != dnsc_pkg::TOTAL_SAT) begin
                nxt.total_count = cur.total_count + 1'b1;
            end
            if (ch == dnsc_pkg::CH_DOT) begin
                if (cur.pending_hyphen || cur.label_count == '0) begin
                    nxt.failed = 1'b1;
                end
                nxt.seen_dot       = 1'b1;
                nxt.prev_dot       = 1'b1;
                nxt.pending_hyphen = 1'b0;
                nxt.label_count    = '0;
            end else if (ch == dnsc_pkg::CH_HYPHEN) begin
                nxt.prev_dot       = 1'b0;
                nxt.pending_hyphen = 1'b1;
                nxt.label_count    = label_grow;
                if (cur.label_count == '0 || label_over) begin
                    nxt.failed = 1'b1;
                end
            end else if (dnsc_pkg::is_alnum(ch)) begin
                nxt.prev_dot       = 1'b0;
                nxt.pending_hyphen = 1'b0;
                nxt.label_count    = label_grow;
                if (label_over) begin
                    nxt.failed = 1'b1;
                end
            end else begin
                nxt.failed         = 1'b1;
                nxt.prev_dot       = 1'b0;
                nxt.pending_hyphen = 1'b0;
            end
        end
    end

endmodule

// ===== sv/dnsc_outq.sv =====
`timescale 1ns / 1ps

module dnsc_outq (
    input  logic               aclk,
    input  logic               aresetn,
    input  dnsc_pkg::verdict_t verdict,
    output logic               space,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic               m_res
);

    logic main_valid_reg, main_valid_next;
    logic main_data_reg,  main_data_next;
    logic skid_valid_reg, skid_valid_next;
    logic skid_data_reg,  skid_data_next;
    logic pop;

    assign pop      = main_valid_reg && m_tready;
    assign space    = !skid_valid_reg;
    assign m_tvalid = main_valid_reg;
    assign m_res    = main_data_reg;

    always_comb begin
        main_valid_next = main_valid_reg;
        main_data_next  = main_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (pop) begin
            if (skid_valid_reg) begin
                main_data_next  = skid_data_reg;
                skid_valid_next = verdict.push;
                skid_data_next  = verdict.valid_res;
            end else begin
                main_valid_next = verdict.push;
                main_data_next  = verdict.valid_res;
            end
        end else if (verdict.push) begin
            if (!main_valid_reg) begin
                main_valid_next = 1'b1;
                main_data_next  = verdict.valid_res;
            end else begin
                skid_valid_next = 1'b1;
                skid_data_next  = verdict.valid_res;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        main_data_reg <= main_data_next;
        skid_data_reg <= skid_data_next;
    end

`ifndef ASSERT_OFF
    a_skid_behind_main: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid entry held without a main entry");
    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (skid_valid_reg && !pop) |=> $stable(skid_data_reg))
        else $error("skid entry overwritten while full");
`endif

endmodule

// ===== sv/domain_name_syntax_check.sv =====
`timescale 1ns / 1ps

// Channel   | Direction | Ports                       | Contents
// ----------+-----------+-----------------------------+------------------------------
// byte in   | slave     | s_tvalid s_tready s_tdata   | tdata[7:0] = ch
// verdict   | master    | m_tvalid m_tready m_tdata   | tdata[0] = valid_res, [7:1] = 0
// config    | APB       | psel penable pwrite paddr.. | 0x0 max_length, 0x4 max_label
//
// One byte is taken per cycle while s_tready is high; the per-name state registers
// are updated in the same edge that accepts the byte, through one level of
// classify-and-compare logic. A zero byte's verdict is written at that edge into
// a two-entry output buffer and leaves on m_tdata; s_tready drops only when both entries
// hold verdicts, so non-terminator bytes keep flowing while a verdict waits.
// Reset (aresetn, synchronous, active low) clears the name state, the buffer and
// loads max_length = 253, max_label = 63.

module domain_name_syntax_check (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] ch
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [0] valid_res, [7:1] zero
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    dnsc_pkg::scan_state_t state_reg, state_next;
    dnsc_pkg::verdict_t    rule_verdict, push_verdict;
    logic [7:0]            max_length_reg;
    logic [5:0]            max_label_reg;
    logic                  accept;
    logic                  space;
    logic                  res_bit;
    logic                  wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // Configuration registers: index is paddr[2], low address bits ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_length_reg <= dnsc_pkg::MAX_LENGTH_RST;
            max_label_reg  <= dnsc_pkg::MAX_LABEL_RST;
        end else if (wr_en) begin
            case (paddr[2])
                dnsc_pkg::REG_MAX_LENGTH: max_length_reg <= pwdata[7:0];
                dnsc_pkg::REG_MAX_LABEL:  max_label_reg  <= pwdata[5:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            dnsc_pkg::REG_MAX_LENGTH: prdata = {24'd0, max_length_reg};
            dnsc_pkg::REG_MAX_LABEL:  prdata = {26'd0, max_label_reg};
            default:                  prdata = '0;
        endcase
    end

    assign s_tready = space;
    assign accept   = s_tvalid && s_tready;

    dnsc_rule u_rule (
        .ch         (s_tdata),
        .cur        (state_reg),
        .max_length (max_length_reg),
        .max_label  (max_label_reg),
        .nxt        (state_next),
        .verdict    (rule_verdict)
    );

    // Hand a verdict to the buffer only for an accepted terminator
    always_comb begin
        push_verdict      = rule_verdict;
        push_verdict.push = rule_verdict.push && accept;
    end

    // Advance name state on every accepted byte; hold otherwise
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (accept) begin
            state_reg <= state_next;
        end
    end

    dnsc_outq u_outq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .verdict  (push_verdict),
        .space    (space),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_res    (res_bit)
    );

    assign m_tdata = {7'd0, res_bit};

`ifndef ASSERT_OFF
    a_stall_means_backlog: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no verdict pending");
    a_clear_after_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_tdata == dnsc_pkg::CH_END) |=> (state_reg == '0))
        else $error("name state not cleared after terminator");
    a_verdict_follows_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_tdata == dnsc_pkg::CH_END) |=> m_tvalid)
        else $error("terminator accepted without a verdict");
    a_prev_dot_implies_seen: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.prev_dot |-> (state_reg.seen_dot && !state_reg.pending_hyphen))
        else $error("inconsistent dot flags");
`endif

endmodule
